>>> src/assert_macros.svh
// Assertion shorthands for the date/hour adder.
// Expects clk and arst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CAH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define CAH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/cah_pkg.sv
// Shared types, constants and microcode for the date/hour adder.
// No dependencies; every file that uses it refers to it by scoped names.
package cah_pkg;

	// field widths
	localparam int YEAR_W  = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int ADD_W   = 16;

	// number of add_hours bits that take part in the sum
	localparam int ADD_HOURS_WIDTH = 16;
	localparam int AH_W = (ADD_HOURS_WIDTH < ADD_W) ? ADD_HOURS_WIDTH : ADD_W;

	// hour sum and day carry; sum / 24 = (sum >> 3) / 3
	localparam int SUM_W   = AH_W + 1;
	localparam int X_W     = SUM_W - 3;
	localparam int CARRY_W = X_W - 1;
	localparam int V_W     = CARRY_W + 1;
	localparam int RECIP3  = ((1 << (X_W + 1)) + 2) / 3;

	// year / 100 = (year >> 2) / 25
	localparam int Y_X_W   = YEAR_W - 2;
	localparam int R25_SH  = Y_X_W + 5;
	localparam int R25_W   = 15;
	localparam int RECIP25 = ((1 << R25_SH) + 24) / 25;
	localparam int Q100_W  = Y_X_W + R25_W - R25_SH;
	localparam int R100_W  = 7;

	localparam int HOURS_PER_DAY = 24;
	localparam int MONTHS        = 12;
	localparam int CENTURY       = 100;
	localparam int FEBRUARY      = 2;
	localparam int FEB_LEAP_DAYS = 29;
	localparam int FEB_DAYS      = 28;

	localparam logic [MONTH_W-1:0] JANUARY = MONTH_W'(1);

	// month lengths; out-of-range month codes count as 31 days
	localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
		5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
	};

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		len = MONTH_LEN[m];
		if (m == MONTH_W'(FEBRUARY)) begin
			len = leap ? DAY_W'(FEB_LEAP_DAYS) : DAY_W'(FEB_DAYS);
		end
		return len;
	endfunction

	// microcode
	typedef enum logic [2:0] {
		OP_WAIT,
		OP_DIV24,
		OP_HOUR,
		OP_DIV100,
		OP_LEAP,
		OP_STEP,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_CARRY_ZERO,
		COND_FITS,
		COND_OUT_FREE
	} cond_t;

	localparam int PC_W = 3;
	localparam int UC_DEPTH = 1 << PC_W;

	localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
	localparam logic [PC_W-1:0] PC_DIV24  = 3'd1;
	localparam logic [PC_W-1:0] PC_HOUR   = 3'd2;
	localparam logic [PC_W-1:0] PC_DIV100 = 3'd3;
	localparam logic [PC_W-1:0] PC_LEAP   = 3'd4;
	localparam logic [PC_W-1:0] PC_STEP   = 3'd5;
	localparam logic [PC_W-1:0] PC_DONE   = 3'd6;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] jt;
		logic [PC_W-1:0] jf;
	} uword_t;

	localparam uword_t UCODE [UC_DEPTH] = '{
		'{OP_WAIT,   COND_IN_VALID,   PC_DIV24,  PC_WAIT},
		'{OP_DIV24,  COND_ALWAYS,     PC_HOUR,   PC_HOUR},
		'{OP_HOUR,   COND_CARRY_ZERO, PC_DONE,   PC_DIV100},
		'{OP_DIV100, COND_ALWAYS,     PC_LEAP,   PC_LEAP},
		'{OP_LEAP,   COND_ALWAYS,     PC_STEP,   PC_STEP},
		'{OP_STEP,   COND_FITS,       PC_DONE,   PC_STEP},
		'{OP_DONE,   COND_OUT_FREE,   PC_WAIT,   PC_DONE},
		'{OP_WAIT,   COND_IN_VALID,   PC_DIV24,  PC_WAIT}
	};

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic carry_zero;
		logic fits;
		logic out_free;
	} status_t;

endpackage

>>> src/cah_if.sv
// Request and result channel interfaces of the date/hour adder.
// Depends on cah_pkg for the field widths.
interface cah_req_if;
	logic                          valid;
	logic                          ready;
	logic [cah_pkg::YEAR_W-1:0]    start_year;
	logic [cah_pkg::MONTH_W-1:0]   start_month;
	logic [cah_pkg::DAY_W-1:0]     start_day;
	logic [cah_pkg::HOUR_W-1:0]    start_hour;
	logic [cah_pkg::ADD_W-1:0]     add_hours;

	modport source (output valid, start_year, start_month, start_day, start_hour,
		add_hours, input ready);
	modport sink (input valid, start_year, start_month, start_day, start_hour,
		add_hours, output ready);
endinterface

interface cah_res_if;
	logic                          valid;
	logic                          ready;
	logic [cah_pkg::YEAR_W-1:0]    new_year;
	logic [cah_pkg::MONTH_W-1:0]   new_month;
	logic [cah_pkg::DAY_W-1:0]     new_day;
	logic [cah_pkg::HOUR_W-1:0]    new_hour;

	modport source (output valid, new_year, new_month, new_day, new_hour, input ready);
	modport sink (input valid, new_year, new_month, new_day, new_hour, output ready);
endinterface

>>> src/cah_useq.sv
// Microcode sequencer: step counter, control store and branch logic.
// Depends on cah_pkg for the control words and status flags.
module cah_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  cah_pkg::status_t status,
	output cah_pkg::op_t     op
);

	logic [cah_pkg::PC_W-1:0] pc_q;
	logic [cah_pkg::PC_W-1:0] pc_next;
	cah_pkg::uword_t          word;
	logic                     taken;

	assign word = cah_pkg::UCODE[pc_q];
	assign op   = word.op;

	always_comb begin
		case (word.cond)
			cah_pkg::COND_ALWAYS:     taken = 1'b1;
			cah_pkg::COND_IN_VALID:   taken = status.in_valid;
			cah_pkg::COND_CARRY_ZERO: taken = status.carry_zero;
			cah_pkg::COND_FITS:       taken = status.fits;
			cah_pkg::COND_OUT_FREE:   taken = status.out_free;
			default:                  taken = 1'b1;
		endcase
		pc_next = taken ? word.jt : word.jf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= cah_pkg::PC_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

>>> src/calendar_add_hours.sv
// Gregorian date/hour adder: top level with the datapath.
// Depends on cah_pkg, cah_if.sv, cah_useq.sv and assert_macros.svh.
//
// Usage:
//  - request carries start_year/month/day/hour and add_hours; it is taken
//    at a rising edge with valid and ready both high.
//  - result carries new_year/month/day/hour under the same valid/ready rule.
//  - One request is worked on at a time. A short microprogram steps a plain
//    datapath: split the hour sum into hour and day carry, find the year's
//    place in its century, then walk the carry off one month per cycle.
//  - With no day carried, the program goes from the hour step straight to
//    the result; otherwise the month walk crosses one month boundary per
//    step (at most about 90 for a 16-bit hour count). Request ready
//    returns in the cycle after the result is loaded.
//  - The result sits in an output register. A new request is taken while
//    that result waits; only loading the next result waits on the receiver.
//  - Reset clears the step counter and the result valid flag; the block
//    is ready for a request in the first cycle after reset.
`include "assert_macros.svh"

module calendar_add_hours (
	input  logic       clk,
	input  logic       arst_n,
	cah_req_if.sink    request,
	cah_res_if.source  result
);

	cah_pkg::op_t     op;
	cah_pkg::status_t status;

	// working registers
	logic [cah_pkg::YEAR_W-1:0]   year_q;
	logic [cah_pkg::MONTH_W-1:0]  month_q;
	logic [cah_pkg::DAY_W-1:0]    day_q;
	logic [cah_pkg::SUM_W-1:0]    sum_q;
	logic [cah_pkg::CARRY_W-1:0]  carry_q;
	logic [cah_pkg::HOUR_W-1:0]   hour_q;
	logic [cah_pkg::V_W-1:0]      v_q;
	logic [cah_pkg::Q100_W-1:0]   q100_q;
	logic [cah_pkg::R100_W-1:0]   r100_q;
	logic [1:0]                   c4_q;

	// result register
	logic                         out_valid_q;
	logic [cah_pkg::YEAR_W-1:0]   new_year_q;
	logic [cah_pkg::MONTH_W-1:0]  new_month_q;
	logic [cah_pkg::DAY_W-1:0]    new_day_q;
	logic [cah_pkg::HOUR_W-1:0]   new_hour_q;

	// combinational datapath values
	logic                                 accept;
	logic                                 out_free;
	logic [cah_pkg::SUM_W-1:0]            in_sum;
	logic [2*cah_pkg::X_W-1:0]            prod3;
	logic [cah_pkg::SUM_W-1:0]            hour_rem;
	logic [cah_pkg::Y_X_W+cah_pkg::R25_W-1:0] prod25;
	logic [cah_pkg::YEAR_W-1:0]           year_rem;
	logic                                 leap;
	logic [cah_pkg::DAY_W-1:0]            len;
	logic                                 fits;

	cah_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	assign request.ready = (op == cah_pkg::OP_WAIT);
	assign accept        = request.valid && request.ready;
	assign out_free      = !out_valid_q || result.ready;

	// hour sum over the used low bits of add_hours
	assign in_sum = cah_pkg::SUM_W'(request.add_hours[cah_pkg::AH_W-1:0])
		+ cah_pkg::SUM_W'(request.start_hour);

	// day carry = floor((sum >> 3) / 3) by reciprocal multiply
	assign prod3 = (2*cah_pkg::X_W)'(sum_q[cah_pkg::SUM_W-1:3])
		* (2*cah_pkg::X_W)'(cah_pkg::RECIP3);

	// hour of day = sum - 24 * carry
	assign hour_rem = sum_q
		- cah_pkg::SUM_W'(carry_q) * cah_pkg::SUM_W'(cah_pkg::HOURS_PER_DAY);

	// century = floor((year >> 2) / 25) by reciprocal multiply
	assign prod25 = (cah_pkg::Y_X_W + cah_pkg::R25_W)'(year_q[cah_pkg::YEAR_W-1:2])
		* (cah_pkg::Y_X_W + cah_pkg::R25_W)'(cah_pkg::RECIP25);

	// year within its century
	assign year_rem = year_q
		- cah_pkg::YEAR_W'(q100_q) * cah_pkg::YEAR_W'(cah_pkg::CENTURY);

	// leap: divisible by 4 but not by 100, or by 400
	assign leap = ((year_q[1:0] == 2'd0) && (r100_q != '0))
		|| ((r100_q == '0) && (c4_q == 2'd0));
	assign len  = cah_pkg::days_in(month_q, leap);
	assign fits = (v_q <= cah_pkg::V_W'(len));

	always_comb begin
		status.in_valid   = request.valid;
		status.carry_zero = (carry_q == '0);
		status.fits       = fits;
		status.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		case (op)
			cah_pkg::OP_WAIT: begin
				// capture the request
				if (accept) begin
					year_q  <= request.start_year;
					month_q <= request.start_month;
					day_q   <= request.start_day;
					sum_q   <= in_sum;
				end
			end
			cah_pkg::OP_DIV24: begin
				carry_q <= prod3[cah_pkg::X_W+1 +: cah_pkg::CARRY_W];
			end
			cah_pkg::OP_HOUR: begin
				hour_q <= hour_rem[cah_pkg::HOUR_W-1:0];
				v_q    <= cah_pkg::V_W'(day_q) + cah_pkg::V_W'(carry_q);
			end
			cah_pkg::OP_DIV100: begin
				q100_q <= prod25[cah_pkg::R25_SH +: cah_pkg::Q100_W];
			end
			cah_pkg::OP_LEAP: begin
				r100_q <= year_rem[cah_pkg::R100_W-1:0];
				c4_q   <= q100_q[1:0];
			end
			cah_pkg::OP_STEP: begin
				// drop one month's days and advance to the next month
				if (!fits) begin
					v_q <= v_q - cah_pkg::V_W'(len);
					if (month_q == '0) begin
						month_q <= cah_pkg::JANUARY;
					end else if (month_q >= cah_pkg::MONTH_W'(cah_pkg::MONTHS)) begin
						month_q <= cah_pkg::JANUARY;
						year_q  <= year_q + 1'b1;
						// keep the century position in step; year wraps to zero
						if (year_q == '1) begin
							r100_q <= '0;
							c4_q   <= 2'd0;
						end else if (r100_q == cah_pkg::R100_W'(cah_pkg::CENTURY - 1)) begin
							r100_q <= '0;
							c4_q   <= c4_q + 1'b1;
						end else begin
							r100_q <= r100_q + 1'b1;
						end
					end else begin
						month_q <= month_q + 1'b1;
					end
				end
			end
			cah_pkg::OP_DONE: begin
				if (out_free) begin
					new_year_q  <= year_q;
					new_month_q <= month_q;
					new_day_q   <= v_q[cah_pkg::DAY_W-1:0];
					new_hour_q  <= hour_q;
				end
			end
			default: begin
			end
		endcase
	end

	// result valid: set on load, clear when taken and nothing new replaces it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((op == cah_pkg::OP_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.new_year  = new_year_q;
	assign result.new_month = new_month_q;
	assign result.new_day   = new_day_q;
	assign result.new_hour  = new_hour_q;

	// checks
	`CAH_ASSERT_NEXT(a_accept_starts_div, accept, op == cah_pkg::OP_DIV24,
		"accepted request did not start the program")
	`CAH_ASSERT_NEXT(a_hour_range, op == cah_pkg::OP_HOUR,
		hour_q < cah_pkg::HOUR_W'(cah_pkg::HOURS_PER_DAY), "hour of day out of range")
	`CAH_ASSERT(a_step_state, (op == cah_pkg::OP_STEP)
		|-> (v_q != '0 && r100_q < cah_pkg::R100_W'(cah_pkg::CENTURY)),
		"month walk state out of range")
	`CAH_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(op == cah_pkg::OP_DONE),
		"result raised outside the final step")

endmodule
